### rtl/core/akf_pkg.sv
// Package: shared types, codes, saturation helpers and the update microprogram.
`timescale 1ns / 1ps
`default_nettype none
package akf_pkg;

  // Item modes
  localparam logic [1:0] MODE_UPDATE  = 2'd0;
  localparam logic [1:0] MODE_SETVEL  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_BETA = 2'd0;
  localparam logic [1:0] REG_RN   = 2'd1;
  localparam logic [1:0] REG_Q1   = 2'd2;
  localparam logic [1:0] REG_Q2   = 2'd3;

  // Shared unit operations
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;
  localparam logic [1:0] OP_GAIN = 2'd3;

  // Operand codes: bit 5 clear selects the scratch RAM
  localparam logic [5:0] P11 = 6'd0, P12 = 6'd1, P13 = 6'd2;
  localparam logic [5:0] P21 = 6'd3, P22 = 6'd4, P23 = 6'd5;
  localparam logic [5:0] P31 = 6'd6, P32 = 6'd7, P33 = 6'd8;
  localparam logic [5:0] X0  = 6'd9,  X1  = 6'd10, OPB = 6'd11, SS  = 6'd12;
  localparam logic [5:0] TV  = 6'd13, TA  = 6'd14, TB  = 6'd15;
  localparam logic [5:0] N11 = 6'd16, N12 = 6'd17, N13 = 6'd18;
  localparam logic [5:0] N21 = 6'd19, N22 = 6'd20, N23 = 6'd21;
  localparam logic [5:0] N31 = 6'd22, N32 = 6'd23, N33 = 6'd24;
  localparam logic [5:0] TE  = 6'd25, OMK = 6'd26;
  localparam logic [5:0] VEL = 6'd32, ALT = 6'd33, BIAS = 6'd34;
  localparam logic [5:0] BETA = 6'd35, RN = 6'd36, Q1 = 6'd37, Q2 = 6'd38;
  localparam logic [5:0] ZM = 6'd39, ACC = 6'd40, STEP = 6'd41, ONE = 6'd42;

  localparam int        COV_N     = 9;
  localparam int        RAM_DEPTH = 32;
  localparam logic [6:0] PROG_LAST = 7'd73;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] dst;
    logic [5:0] a;
    logic [5:0] b;
  } uop_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7fff_ffff) r = 32'sh7fff_ffff;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic uop_t mk(input logic [1:0] op, input logic [5:0] d,
                              input logic [5:0] a, input logic [5:0] b);
    uop_t u;
    u.op = op; u.dst = d; u.a = a; u.b = b;
    return u;
  endfunction

  // Predict, gain, correct and covariance update, one operation per entry
  function automatic uop_t akf_prog(input logic [6:0] pc);
    uop_t u;
    unique case (pc)
      7'd0:  u = mk(OP_MUL, X0, BETA, STEP);
      7'd1:  u = mk(OP_ADD, OPB, ONE, X0);
      7'd2:  u = mk(OP_MUL, SS, STEP, STEP);
      7'd3:  u = mk(OP_SUB, X0, ACC, BIAS);
      7'd4:  u = mk(OP_MUL, X0, X0, STEP);
      7'd5:  u = mk(OP_ADD, TV, VEL, X0);
      7'd6:  u = mk(OP_MUL, X0, VEL, STEP);
      7'd7:  u = mk(OP_ADD, TA, ALT, X0);
      7'd8:  u = mk(OP_MUL, TB, BIAS, OPB);
      7'd9:  u = mk(OP_ADD, X0, P31, P13);
      7'd10: u = mk(OP_MUL, X0, STEP, X0);
      7'd11: u = mk(OP_SUB, X0, P11, X0);
      7'd12: u = mk(OP_MUL, X1, SS, P33);
      7'd13: u = mk(OP_ADD, X0, X0, X1);
      7'd14: u = mk(OP_MUL, X1, SS, Q1);
      7'd15: u = mk(OP_ADD, N11, X0, X1);
      7'd16: u = mk(OP_SUB, X0, P11, P32);
      7'd17: u = mk(OP_MUL, X0, STEP, X0);
      7'd18: u = mk(OP_MUL, X1, SS, P31);
      7'd19: u = mk(OP_SUB, X0, X0, X1);
      7'd20: u = mk(OP_ADD, N12, X0, P12);
      7'd21: u = mk(OP_MUL, X0, STEP, P33);
      7'd22: u = mk(OP_SUB, X0, P13, X0);
      7'd23: u = mk(OP_MUL, N13, OPB, X0);
      7'd24: u = mk(OP_SUB, X0, P11, P23);
      7'd25: u = mk(OP_MUL, X0, STEP, X0);
      7'd26: u = mk(OP_MUL, X1, SS, P13);
      7'd27: u = mk(OP_SUB, X0, X0, X1);
      7'd28: u = mk(OP_ADD, N21, X0, P21);
      7'd29: u = mk(OP_MUL, X0, SS, P11);
      7'd30: u = mk(OP_ADD, X1, P21, P12);
      7'd31: u = mk(OP_MUL, X1, STEP, X1);
      7'd32: u = mk(OP_ADD, X0, X0, X1);
      7'd33: u = mk(OP_ADD, N22, X0, P22);
      7'd34: u = mk(OP_MUL, X0, STEP, P13);
      7'd35: u = mk(OP_ADD, X0, P23, X0);
      7'd36: u = mk(OP_MUL, N23, OPB, X0);
      7'd37: u = mk(OP_MUL, X0, STEP, P33);
      7'd38: u = mk(OP_SUB, X0, P31, X0);
      7'd39: u = mk(OP_MUL, N31, OPB, X0);
      7'd40: u = mk(OP_MUL, X0, STEP, P31);
      7'd41: u = mk(OP_ADD, X0, P32, X0);
      7'd42: u = mk(OP_MUL, N32, OPB, X0);
      7'd43: u = mk(OP_MUL, X0, OPB, OPB);
      7'd44: u = mk(OP_MUL, X0, X0, P33);
      7'd45: u = mk(OP_MUL, X1, SS, Q2);
      7'd46: u = mk(OP_ADD, N33, X0, X1);
      // innovation variance, then the three gains
      7'd47: u = mk(OP_ADD, SS, N22, RN);
      7'd48: u = mk(OP_GAIN, OPB, N12, SS);
      7'd49: u = mk(OP_GAIN, X1, N22, SS);
      7'd50: u = mk(OP_GAIN, SS, N32, SS);
      7'd51: u = mk(OP_SUB, TE, ZM, TA);
      7'd52: u = mk(OP_MUL, X0, OPB, TE);
      7'd53: u = mk(OP_ADD, VEL, TV, X0);
      7'd54: u = mk(OP_MUL, X0, X1, TE);
      7'd55: u = mk(OP_ADD, ALT, TA, X0);
      7'd56: u = mk(OP_MUL, X0, SS, TE);
      7'd57: u = mk(OP_ADD, BIAS, TB, X0);
      7'd58: u = mk(OP_SUB, OMK, ONE, X1);
      7'd59: u = mk(OP_MUL, X0, OPB, N21);
      7'd60: u = mk(OP_SUB, P11, N11, X0);
      7'd61: u = mk(OP_MUL, X0, OPB, N22);
      7'd62: u = mk(OP_SUB, P12, N12, X0);
      7'd63: u = mk(OP_MUL, X0, OPB, N23);
      7'd64: u = mk(OP_SUB, P13, N13, X0);
      7'd65: u = mk(OP_MUL, P21, N21, OMK);
      7'd66: u = mk(OP_MUL, P22, N22, OMK);
      7'd67: u = mk(OP_MUL, P23, N23, OMK);
      7'd68: u = mk(OP_MUL, X0, SS, N21);
      7'd69: u = mk(OP_SUB, P31, N31, X0);
      7'd70: u = mk(OP_MUL, X0, SS, N22);
      7'd71: u = mk(OP_SUB, P32, N32, X0);
      7'd72: u = mk(OP_MUL, X0, SS, N23);
      7'd73: u = mk(OP_SUB, P33, N33, X0);
      default: u = mk(OP_ADD, X0, X0, X0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

### rtl/core/akf_in_if.sv
// Interface: input request channel of the altitude filter.
`timescale 1ns / 1ps
`default_nettype none
interface akf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] measured_altitude;
  logic signed [31:0] vertical_accel;
  logic [15:0]        time_step;
  logic signed [31:0] new_velocity;

  modport source (output valid, mode, measured_altitude, vertical_accel, time_step,
                  new_velocity, input ready);
  modport sink (input valid, mode, measured_altitude, vertical_accel, time_step,
                new_velocity, output ready);
endinterface
`default_nettype wire

### rtl/core/akf_out_if.sv
// Interface: result channel of the altitude filter.
`timescale 1ns / 1ps
`default_nettype none
interface akf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_velocity;
  logic signed [31:0] est_altitude;
  logic signed [31:0] est_bias;
  logic               gain_saturated;

  modport source (output valid, est_velocity, est_altitude, est_bias, gain_saturated,
                  input ready);
  modport sink (input valid, est_velocity, est_altitude, est_bias, gain_saturated,
                output ready);
endinterface
`default_nettype wire

### rtl/core/akf_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module akf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output      logic [WIDTH-1:0]         rd_data_a,
  output      logic [WIDTH-1:0]         rd_data_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule
`default_nettype wire

### rtl/core/altitude_kalman_filter_core.sv
// Altitude Kalman filter: the top level, a microcoded sequencer around one shared unit.
//
// Requests arrive on in_ch (valid/ready); each carries a mode, an altitude reading,
// an acceleration, a time step and a velocity. Every request yields one result on
// out_ch: the velocity, altitude and bias estimates after the request, plus a flag
// that is set when the innovation variance was not positive.
// The user must write the registers through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. An update request runs
// a 74-step program on one add/subtract, multiply and divide unit, each step going
// through RAM read, execute and write back; each of the three gains with a positive
// divisor adds a pass through a restoring divider. A result is loaded when its
// request is done and the output register is free; the next request can be taken
// in the cycle after that. Set-velocity, restart and the unused mode skip the program.
// in_ch.ready is high only while the sequencer is idle and rst is low.
// A finished result sits in the output register until taken; the block accepts the
// next request meanwhile and holds its result back until the register is free.
// Reset (rst, synchronous) clears the estimates, marks the covariance as its
// reset value (100 on the diagonal) through per-entry valid bits, and restores
// the registers. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module altitude_kalman_filter_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  akf_in_if.sink           in_ch,
  akf_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import akf_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam int AW = $clog2(RAM_DEPTH);
  localparam logic signed [63:0] HUNDRED_W = 64'sd100 <<< FRAC_BITS;
  localparam logic signed [31:0] HUNDRED =
      (HUNDRED_W > 64'sh7fff_ffff) ? 32'sh7fff_ffff : HUNDRED_W[31:0];
  localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [DW-1:0] Q_MAX = DW'(32'h7fff_ffff);
  localparam logic [DW-1:0] Q_NEG = DW'(33'h1_0000_0000) >> 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state;
  logic [6:0] pc;
  uop_t       uop;

  // Registers and latched request
  logic signed [31:0] beta;
  logic [30:0]        rnoise, q1n, q2n;
  logic [1:0]         item_mode;
  logic signed [31:0] z_in, acc_in;
  logic [15:0]        step_in;
  logic signed [31:0] vel, alt, bias;
  logic               flag;
  logic [COV_N-1:0]   cov_valid;

  // Shared unit
  logic signed [31:0] opa, opb_v, res, wval;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic [32:0]        div_rem;
  logic [DW-1:0]      div_q;
  logic [31:0]        div_den;
  logic               div_neg;
  logic [CW-1:0]      div_cnt;
  logic [32:0]        trial;
  logic [31:0]        amag;

  logic [31:0] ram_a, ram_b;
  logic        ram_we;
  logic        accept, out_load;

  assign uop    = akf_prog(pc);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !rst;
  assign out_load = (state == ST_DONE) && (!out_ch.valid || out_ch.ready);
  assign ram_we = (state == ST_WB) && !uop.dst[5];

  akf_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (uop.dst[AW-1:0]),
    .wr_data   (wval),
    .rd_addr_a (uop.a[AW-1:0]),
    .rd_addr_b (uop.b[AW-1:0]),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  // Operand select; unwritten covariance entries read as their reset value
  function automatic logic signed [31:0] operand(input logic [5:0] code,
                                                 input logic [31:0] rdata);
    logic signed [31:0] v;
    v = '0;
    if (!code[5]) begin
      if (code < 6'(COV_N) && !cov_valid[code[3:0]]) begin
        v = (code == P11 || code == P22 || code == P33) ? HUNDRED : 32'sd0;
      end else begin
        v = rdata;
      end
    end else begin
      unique case (code)
        VEL:  v = vel;
        ALT:  v = alt;
        BIAS: v = bias;
        BETA: v = beta;
        RN:   v = {1'b0, rnoise};
        Q1:   v = {1'b0, q1n};
        Q2:   v = {1'b0, q2n};
        ZM:   v = z_in;
        ACC:  v = acc_in;
        STEP: v = {16'd0, step_in};
        ONE:  v = FX_ONE;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  assign opa     = operand(uop.a, ram_a);
  assign opb_v   = operand(uop.b, ram_b);
  assign prod_sh = prod >>> FRAC_BITS;
  assign wval    = (uop.op == OP_MUL) ? sat64(prod_sh) : res;
  assign trial   = {div_rem[31:0], div_q[DW-1]};
  assign amag    = opa[31] ? 32'(-opa) : 32'(opa);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beta   <= '0;
      rnoise <= 31'(FX_ONE);
      q1n    <= 31'(FX_ONE);
      q2n    <= 31'(FX_ONE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BETA: beta   <= cfg_data;
        REG_RN:   rnoise <= cfg_data[30:0];
        REG_Q1:   q1n    <= cfg_data[30:0];
        REG_Q2:   q2n    <= cfg_data[30:0];
      endcase
    end
  end

  // Sequencer and shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      vel       <= '0;
      alt       <= '0;
      bias      <= '0;
      flag      <= 1'b0;
      cov_valid <= '0;
      item_mode <= MODE_NONE;
      div_cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item_mode <= in_ch.mode;
            z_in      <= in_ch.measured_altitude;
            acc_in    <= in_ch.vertical_accel;
            step_in   <= in_ch.time_step;
            flag      <= 1'b0;
            pc        <= '0;
            unique case (in_ch.mode)
              MODE_UPDATE: state <= ST_FETCH;
              MODE_SETVEL: begin
                vel   <= in_ch.new_velocity;
                state <= ST_DONE;
              end
              MODE_RESTART: begin
                vel       <= '0;
                alt       <= '0;
                bias      <= '0;
                cov_valid <= '0;
                state     <= ST_DONE;
              end
              MODE_NONE: state <= ST_DONE;
            endcase
          end
        end
        ST_FETCH: state <= ST_EXEC;
        ST_EXEC: begin
          state <= ST_WB;
          unique case (uop.op)
            OP_ADD: res  <= sat33({opa[31], opa} + {opb_v[31], opb_v});
            OP_SUB: res  <= sat33({opa[31], opa} - {opb_v[31], opb_v});
            OP_MUL: prod <= opa * opb_v;
            OP_GAIN: begin
              if (opb_v <= 32'sd0) begin
                flag <= 1'b1;
                res  <= (opa > 32'sd0) ? 32'sh7fff_ffff :
                        (opa < 32'sd0) ? 32'sh8000_0000 : 32'sd0;
              end else begin
                div_rem <= '0;
                div_q   <= {amag, {FRAC_BITS{1'b0}}};
                div_neg <= opa[31];
                div_den <= opb_v;
                div_cnt <= CW'(DW);
                state   <= ST_DIV;
              end
            end
          endcase
        end
        // one quotient bit per cycle, then sign and saturate
        ST_DIV: begin
          if (div_cnt != '0) begin
            if (trial >= {1'b0, div_den}) begin
              div_rem <= trial - {1'b0, div_den};
              div_q   <= {div_q[DW-2:0], 1'b1};
            end else begin
              div_rem <= trial;
              div_q   <= {div_q[DW-2:0], 1'b0};
            end
            div_cnt <= div_cnt - 1'b1;
          end else begin
            if (div_neg) begin
              res <= (div_q > Q_NEG) ? 32'sh8000_0000 : 32'(-div_q[31:0]);
            end else begin
              res <= (div_q > Q_MAX) ? 32'sh7fff_ffff : div_q[31:0];
            end
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (!uop.dst[5]) begin
            if (uop.dst < 6'(COV_N)) cov_valid[uop.dst[3:0]] <= 1'b1;
          end else begin
            unique case (uop.dst)
              VEL:  vel  <= wval;
              ALT:  alt  <= wval;
              BIAS: bias <= wval;
              default: ;
            endcase
          end
          pc    <= pc + 1'b1;
          state <= (pc == PROG_LAST) ? ST_DONE : ST_FETCH;
        end
        ST_DONE: if (out_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.est_velocity   <= vel;
      out_ch.est_altitude   <= alt;
      out_ch.est_bias       <= bias;
      out_ch.gain_saturated <= flag;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE) else $error("request taken but sequencer idle");
  a_start_pc: assert property (@(posedge clk) disable iff (rst)
    accept |=> pc == '0) else $error("program not started at entry zero");
  a_flag_mode: assert property (@(posedge clk) disable iff (rst)
    (out_load && flag) |-> item_mode == MODE_UPDATE)
    else $error("gain flag outside an update");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |=> state == ST_DIV || state == ST_WB)
    else $error("divider left to a wrong state");
`endif

endmodule
`default_nettype wire

### bench/tb_altitude_kalman_filter_core.sv
// Testbench: altitude Kalman filter core, directed table plus random requests against a predictor.
`timescale 1ns / 1ps
module tb_altitude_kalman_filter_core;
  import akf_pkg::*;

  localparam longint FIX_MAX  = 64'sd2147483647;
  localparam longint FIX_MIN  = -64'sd2147483648;
  localparam int     FRAC     = 16;
  localparam longint CYC_CAP  = 64'd4000000;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] alt;
    logic [31:0] acc;
    logic [15:0] step;
    logic [31:0] vel;
    bit          typed;
    logic [31:0] x_vel;
    logic [31:0] x_alt;
    logic [31:0] x_bias;
  } req_row_t;

  typedef struct {
    logic [31:0] vel;
    logic [31:0] alt;
    logic [31:0] bias;
    logic        sat;
  } estimate_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_BETA;
  logic [31:0] cfg_data = 0;

  akf_in_if  in_ch();
  akf_out_if out_ch();

  altitude_kalman_filter_core DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Filter state mirrored by the predictor
  longint beta_r, rn_r, q1_r, q2_r;
  longint vel_e, alt_e, bias_e;
  longint cov[9];

  estimate_t pending_estimates[$];
  int errors = 0;
  int n_sent = 0, n_updates = 0, n_sat = 0, n_results = 0;
  longint cycles = 0;

  function automatic longint sat32(longint x);
    if (x > FIX_MAX) return FIX_MAX;
    if (x < FIX_MIN) return FIX_MIN;
    return x;
  endfunction

  function automatic longint fadd(longint a, longint b);
    return sat32(a + b);
  endfunction

  function automatic longint fsub(longint a, longint b);
    return sat32(a - b);
  endfunction

  // exact product, floor shift, then saturate
  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat32(p >>> FRAC);
  endfunction

  function automatic longint fgain(longint num, longint s);
    if (s <= 0) begin
      if (num > 0) return FIX_MAX;
      if (num < 0) return FIX_MIN;
      return 0;
    end
    return sat32((num * (64'sd1 <<< FRAC)) / s);
  endfunction

  function automatic void restart_estimates();
    for (int i = 0; i < 9; i++) cov[i] = 0;
    cov[0] = 100 * (64'sd1 <<< FRAC);
    cov[4] = cov[0];
    cov[8] = cov[0];
    vel_e = 0;
    alt_e = 0;
    bias_e = 0;
  endfunction

  // One update: predict, gains, correction, covariance; returns the saturation flag
  function automatic bit kalman_update(longint z, longint acc, longint dt);
    longint one, opb, ss, v_, a_, b_, s, k1, k2, k3, e, omk;
    longint n11, n12, n13, n21, n22, n23, n31, n32, n33;
    one = 64'sd1 <<< FRAC;
    opb = fadd(one, fmul(beta_r, dt));
    ss = fmul(dt, dt);
    v_ = fadd(vel_e, fmul(fsub(acc, bias_e), dt));
    a_ = fadd(alt_e, fmul(vel_e, dt));
    b_ = fmul(bias_e, opb);
    n11 = fadd(fadd(fsub(cov[0], fmul(dt, fadd(cov[6], cov[2]))), fmul(ss, cov[8])),
               fmul(ss, q1_r));
    n12 = fadd(fsub(fmul(dt, fsub(cov[0], cov[7])), fmul(ss, cov[6])), cov[1]);
    n13 = fmul(opb, fsub(cov[2], fmul(dt, cov[8])));
    n21 = fadd(fsub(fmul(dt, fsub(cov[0], cov[5])), fmul(ss, cov[2])), cov[3]);
    n22 = fadd(fadd(fmul(ss, cov[0]), fmul(dt, fadd(cov[3], cov[1]))), cov[4]);
    n23 = fmul(opb, fadd(cov[5], fmul(dt, cov[2])));
    n31 = fmul(opb, fsub(cov[6], fmul(dt, cov[8])));
    n32 = fmul(opb, fadd(cov[7], fmul(dt, cov[6])));
    n33 = fadd(fmul(fmul(opb, opb), cov[8]), fmul(ss, q2_r));
    s = fadd(n22, rn_r);
    k1 = fgain(n12, s);
    k2 = fgain(n22, s);
    k3 = fgain(n32, s);
    e = fsub(z, a_);
    vel_e = fadd(v_, fmul(k1, e));
    alt_e = fadd(a_, fmul(k2, e));
    bias_e = fadd(b_, fmul(k3, e));
    omk = fsub(one, k2);
    cov[0] = fsub(n11, fmul(k1, n21));
    cov[1] = fsub(n12, fmul(k1, n22));
    cov[2] = fsub(n13, fmul(k1, n23));
    cov[3] = fmul(n21, omk);
    cov[4] = fmul(n22, omk);
    cov[5] = fmul(n23, omk);
    cov[6] = fsub(n31, fmul(k3, n21));
    cov[7] = fsub(n32, fmul(k3, n22));
    cov[8] = fsub(n33, fmul(k3, n23));
    return s <= 0;
  endfunction

  function automatic estimate_t predict_request(req_row_t r);
    estimate_t x;
    bit f;
    f = 0;
    case (r.mode)
      MODE_UPDATE:  f = kalman_update(longint'($signed(r.alt)), longint'($signed(r.acc)),
                                      longint'(r.step));
      MODE_SETVEL:  vel_e = longint'($signed(r.vel));
      MODE_RESTART: restart_estimates();
      default: ;
    endcase
    x.vel = vel_e[31:0];
    x.alt = alt_e[31:0];
    x.bias = bias_e[31:0];
    x.sat = f;
    return x;
  endfunction

  // Register write, only while idle; the caller drops the write enable
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_BETA: beta_r = longint'($signed(val));
      REG_RN:   rn_r = longint'(val[30:0]);
      REG_Q1:   q1_r = longint'(val[30:0]);
      REG_Q2:   q2_r = longint'(val[30:0]);
    endcase
  endtask

  task automatic configure(logic [31:0] b, logic [31:0] r, logic [31:0] p1, logic [31:0] p2);
    wait (pending_estimates.size() == 0);
    repeat (400) @(posedge clk);
    write_reg(REG_BETA, b);
    write_reg(REG_RN, r);
    write_reg(REG_Q1, p1);
    write_reg(REG_Q2, p2);
    cfg_we <= 0;
  endtask

  // Drive one request, hold until taken, then an optional gap
  task automatic send_request(req_row_t r, int gap);
    estimate_t x;
    in_ch.valid <= 1;
    in_ch.mode <= r.mode;
    in_ch.measured_altitude <= r.alt;
    in_ch.vertical_accel <= r.acc;
    in_ch.time_step <= r.step;
    in_ch.new_velocity <= r.vel;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    x = predict_request(r);
    if (r.typed) begin
      x.vel = r.x_vel;
      x.alt = r.x_alt;
      x.bias = r.x_bias;
    end
    pending_estimates.push_back(x);
    n_sent++;
    if (r.mode == MODE_UPDATE) n_updates++;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_row_t random_request();
    req_row_t r;
    int m;
    m = $urandom_range(0, 99);
    r.mode = (m < 75) ? MODE_UPDATE : (m < 87) ? MODE_SETVEL :
             (m < 94) ? MODE_RESTART : MODE_NONE;
    r.alt = pick_word();
    r.acc = pick_word();
    r.vel = pick_word();
    case ($urandom_range(0, 5))
      0: r.step = 16'hffff;
      1: r.step = 16'h0000;
      2: r.step = $urandom;
      default: r.step = $urandom_range(1, 2000);
    endcase
    r.typed = 0;
    return r;
  endfunction

  function automatic req_row_t row(logic [1:0] m, logic [31:0] a, logic [31:0] c,
                                   logic [15:0] s, logic [31:0] v);
    req_row_t r;
    r.mode = m; r.alt = a; r.acc = c; r.step = s; r.vel = v;
    r.typed = 0; r.x_vel = 0; r.x_alt = 0; r.x_bias = 0;
    return r;
  endfunction

  function automatic req_row_t known(req_row_t r, logic [31:0] v, logic [31:0] a,
                                     logic [31:0] b);
    r.typed = 1; r.x_vel = v; r.x_alt = a; r.x_bias = b;
    return r;
  endfunction

  // Receiver: check each result, stall on a shifting pattern
  int stall_style = 0;
  always @(posedge clk) begin
    estimate_t x;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.gain_saturated) n_sat++;
      if (pending_estimates.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending (vel %h)", $time, out_ch.est_velocity);
      end else begin
        x = pending_estimates.pop_front();
        if (out_ch.est_velocity !== x.vel) begin
          errors++;
          $display("%0t: est_velocity exp %h got %h", $time, x.vel, out_ch.est_velocity);
        end
        if (out_ch.est_altitude !== x.alt) begin
          errors++;
          $display("%0t: est_altitude exp %h got %h", $time, x.alt, out_ch.est_altitude);
        end
        if (out_ch.est_bias !== x.bias) begin
          errors++;
          $display("%0t: est_bias exp %h got %h", $time, x.bias, out_ch.est_bias);
        end
        if (out_ch.gain_saturated !== x.sat) begin
          errors++;
          $display("%0t: gain_saturated exp %b got %b", $time, x.sat, out_ch.gain_saturated);
        end
      end
    end
    if ($urandom_range(0, 499) == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: out_ch.ready <= 1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default: out_ch.ready <= ((cycles % 97) > 60);
    endcase
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    req_row_t dir[$];
    int burst;
    in_ch.valid = 0;
    in_ch.mode = MODE_NONE;
    in_ch.measured_altitude = 0;
    in_ch.vertical_accel = 0;
    in_ch.time_step = 0;
    in_ch.new_velocity = 0;
    out_ch.ready = 0;
    beta_r = 0;
    rn_r = 64'sd1 <<< FRAC;
    q1_r = rn_r;
    q2_r = rn_r;
    restart_estimates();
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: after reset, extremes, every mode, restart and the unused mode
    dir.push_back(known(row(MODE_NONE, 32'h7fff_ffff, 32'h8000_0000, 16'hffff, 32'h1), 0, 0, 0));
    dir.push_back(row(MODE_UPDATE, 32'h0001_0000, 32'h0, 16'h0148, 32'h0));
    dir.push_back(row(MODE_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 32'h0));
    dir.push_back(row(MODE_UPDATE, 32'h8000_0000, 32'h8000_0000, 16'hffff, 32'h0));
    dir.push_back(row(MODE_UPDATE, 32'h0, 32'h0, 16'h0, 32'h0));
    dir.push_back(row(MODE_NONE, 32'h0, 32'h0, 16'h0, 32'h0));
    dir.push_back(known(row(MODE_RESTART, 32'h1234, 32'h5678, 16'h1, 32'h9), 0, 0, 0));
    dir.push_back(known(row(MODE_SETVEL, 32'h0, 32'h0, 16'h0, 32'h7fff_ffff),
                        32'h7fff_ffff, 0, 0));
    dir.push_back(row(MODE_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 16'h8000, 32'h0));
    dir.push_back(row(MODE_SETVEL, 32'h0, 32'h0, 16'h0, 32'h8000_0000));
    dir.push_back(row(MODE_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 16'h0001, 32'h0));
    dir.push_back(row(MODE_UPDATE, 32'hffff_ffff, 32'h0000_0001, 16'h00a0, 32'h0));
    dir.push_back(known(row(MODE_RESTART, 32'h0, 32'h0, 16'h0, 32'h0), 0, 0, 0));
    foreach (dir[i]) send_request(dir[i], $urandom_range(0, 2));
    in_ch.valid <= 0;

    // Phases of register settings, extremes first, then random requests
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        1: configure(32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h0);
        2: configure(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff);
        3: configure(32'hffff_0000, 32'h0, 32'h0, 32'h0);
        4: configure(32'hffff_ff00, 32'h0000_0100, 32'h0000_0040, 32'h0000_0010);
        default: configure($urandom, $urandom, $urandom, $urandom);
      endcase
      burst = 0;
      for (int k = 0; k < 125; k++) begin
        if (burst == 0) burst = $urandom_range(1, 12);
        burst--;
        send_request(random_request(),
                     (burst == 0 && ph != 6) ? $urandom_range(1, 40) : 0);
      end
      in_ch.valid <= 0;
    end

    wait (pending_estimates.size() == 0);
    repeat (400) @(posedge clk);
    $display("Sent %0d requests (%0d updates) over 8 register settings;", n_sent, n_updates);
    $display("checked %0d results, %0d with the gain flag set.", n_results, n_sat);
    if (errors == 0 && pending_estimates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### sim.f
rtl/core/akf_pkg.sv
rtl/core/akf_in_if.sv
rtl/core/akf_out_if.sv
rtl/core/akf_ram.sv
rtl/core/altitude_kalman_filter_core.sv
bench/tb_altitude_kalman_filter_core.sv
